/* hw/rtl/msbnh_pkg.sv */
// Package for the segment versus box nearest-hit block.
// Holds widths, pipeline stage numbering, register codes and shared structs.
// No dependencies.
package msbnh_pkg;

  localparam int NEDGE = 4;

  localparam int CW   = 18;  // box corner / crossing coordinate, signed
  localparam int XW   = 35;  // cross product, signed
  localparam int TW   = 34;  // magnitude of a cross product
  localparam int SW   = 35;  // sum of two magnitudes
  localparam int QW   = 14;  // quotient bits (offset along an edge)
  localparam int NW   = 50;  // dividend width
  localparam int DW   = 36;  // divisor width
  localparam int VW   = 35;  // squared distance
  localparam int SQN  = 18;  // square root steps
  localparam int DSTW = 18;  // rounded distance

  // Pipeline stage numbering
  localparam int ST_F0  = 0;
  localparam int ST_F1  = 1;
  localparam int ST_F2  = 2;
  localparam int ST_E0  = 3;
  localparam int ST_E1  = 4;
  localparam int ST_DIV = 5;
  localparam int ST_PT  = ST_DIV + QW;
  localparam int ST_SQ  = ST_PT + 1;
  localparam int ST_SUM = ST_SQ + 1;
  localparam int ST_RT  = ST_SUM + 1;
  localparam int ST_RND = ST_RT + SQN;
  localparam int ST_OUT = ST_RND + 1;
  localparam int NST    = ST_OUT + 1;

  // Configuration register indexes
  localparam logic [1:0] CFG_LEFT = 2'd0;
  localparam logic [1:0] CFG_TOP  = 2'd1;
  localparam logic [1:0] CFG_SIDE = 2'd2;

  localparam logic [15:0] RST_LEFT = 16'd1024;
  localparam logic [15:0] RST_TOP  = 16'd1024;
  localparam logic [13:0] RST_SIDE = 14'd1024;

  typedef struct packed {
    logic                 hit;
    logic                 horiz;
    logic                 neg;
    logic signed [CW-1:0] e1x;
    logic signed [CW-1:0] e1y;
    logic signed [15:0]   sx;
    logic signed [15:0]   sy;
    logic [TW-1:0]        t1;
    logic [SW-1:0]        s;
  } edge_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [DSTW-1:0]      hit_dist;
  } edge_res_t;

endpackage

/* hw/rtl/msbnh_ctrl.sv */
// Valid bits and per-stage load enables of the nearest-hit pipeline.
// Depends on msbnh_pkg.
module msbnh_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [msbnh_pkg::NST-1:0]   en
);

  localparam int NST = msbnh_pkg::NST;

  logic [NST-1:0] valid_r, valid_nxt;
  logic [NST:0]   ready;

  // A stage loads when it is empty or its beat moves on.
  always_comb begin
    ready[NST] = out_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      ready[i] = !valid_r[i] | ready[i+1];
    end
  end

  assign en = ready[NST-1:0];

  always_comb begin
    valid_nxt[0] = ready[0] ? in_tvalid : valid_r[0];
    for (int i = 1; i < NST; i++) begin
      valid_nxt[i] = ready[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = ready[0];
  assign out_tvalid = valid_r[NST-1];

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_tvalid && in_tready && !(out_tvalid && out_tready)) |=>
    ($countones(valid_r) == $past($countones(valid_r)) + 1))
    else $error("accepted beat not counted in pipeline");

  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(in_tvalid && in_tready) && out_tvalid && out_tready) |=>
    ($countones(valid_r) + 1 == $past($countones(valid_r))))
    else $error("delivered beat not removed from pipeline");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[0] |-> in_tready)
    else $error("empty first stage refuses input");

endmodule

/* hw/rtl/msbnh_front.sv */
// Front stages: corner offsets, cross products and per-edge crossing tests.
// Depends on msbnh_pkg.
module msbnh_front (
  input  logic                                         clk,
  input  logic [msbnh_pkg::NST-1:0]                    en,
  input  logic signed [15:0]                           start_x,
  input  logic signed [15:0]                           start_y,
  input  logic signed [15:0]                           move_x,
  input  logic signed [15:0]                           move_y,
  input  logic signed [15:0]                           box_left,
  input  logic signed [15:0]                           box_top,
  input  logic [13:0]                                  box_side,
  output msbnh_pkg::edge_in_t [msbnh_pkg::NEDGE-1:0]   edge_o
);

  localparam int CW = msbnh_pkg::CW;
  localparam int XW = msbnh_pkg::XW;
  localparam int TW = msbnh_pkg::TW;
  localparam int SW = msbnh_pkg::SW;
  localparam int PW = 34;
  localparam int UW = 19;
  localparam int NE = msbnh_pkg::NEDGE;

  function automatic logic [1:0] sgn_f(input logic signed [XW-1:0] v);
    return {v[XW-1], |v};
  endfunction

  logic signed [CW-1:0] left_w, top_w, rgt_w, bot_w;

  assign left_w = CW'(box_left);
  assign top_w  = CW'(box_top);
  assign rgt_w  = left_w + CW'(box_side);
  assign bot_w  = top_w + CW'(box_side);

  // Stage 0: offsets of the corners from the start point
  logic signed [15:0]   sx0_r, sy0_r, ax0_r, ay0_r;
  logic signed [CW-1:0] dxl0_r, dxr0_r, dyt0_r, dyb0_r;

  always_ff @(posedge clk) begin
    if (en[msbnh_pkg::ST_F0]) begin
      sx0_r  <= start_x;
      sy0_r  <= start_y;
      ax0_r  <= move_x;
      ay0_r  <= move_y;
      dxl0_r <= left_w - CW'(start_x);
      dxr0_r <= rgt_w - CW'(start_x);
      dyt0_r <= top_w - CW'(start_y);
      dyb0_r <= bot_w - CW'(start_y);
    end
  end

  // Stage 1: the four distinct products
  logic signed [15:0]   sx1_r, sy1_r, ax1_r, ay1_r;
  logic signed [CW-1:0] dxl1_r, dxr1_r, dyt1_r, dyb1_r;
  logic signed [PW-1:0] m_at1_r, m_ab1_r, m_al1_r, m_ar1_r;

  always_ff @(posedge clk) begin
    if (en[msbnh_pkg::ST_F1]) begin
      sx1_r   <= sx0_r;
      sy1_r   <= sy0_r;
      ax1_r   <= ax0_r;
      ay1_r   <= ay0_r;
      dxl1_r  <= dxl0_r;
      dxr1_r  <= dxr0_r;
      dyt1_r  <= dyt0_r;
      dyb1_r  <= dyb0_r;
      m_at1_r <= PW'(ax0_r) * PW'(dyt0_r);
      m_ab1_r <= PW'(ax0_r) * PW'(dyb0_r);
      m_al1_r <= PW'(ay0_r) * PW'(dxl0_r);
      m_ar1_r <= PW'(ay0_r) * PW'(dxr0_r);
    end
  end

  // Stage 2: corner cross products in order top left, top right,
  // bottom right, bottom left; edge k runs from corner k to corner k+1.
  logic signed [XW-1:0] crs_w [NE];
  logic signed [UW-1:0] den_w [NE];
  logic signed [UW-1:0] num_w [NE];
  logic signed [CW-1:0] e1x_w [NE];
  logic signed [CW-1:0] e1y_w [NE];
  msbnh_pkg::edge_in_t  edge_nxt [NE];

  assign crs_w[0] = XW'(m_at1_r) - XW'(m_al1_r);
  assign crs_w[1] = XW'(m_at1_r) - XW'(m_ar1_r);
  assign crs_w[2] = XW'(m_ab1_r) - XW'(m_ar1_r);
  assign crs_w[3] = XW'(m_ab1_r) - XW'(m_al1_r);

  // Segment parameter test with the side length divided out
  assign den_w[0] = -UW'(ay1_r);
  assign den_w[1] = UW'(ax1_r);
  assign den_w[2] = UW'(ay1_r);
  assign den_w[3] = -UW'(ax1_r);
  assign num_w[0] = -UW'(dyt1_r);
  assign num_w[1] = UW'(dxr1_r);
  assign num_w[2] = UW'(dyb1_r);
  assign num_w[3] = -UW'(dxl1_r);

  assign e1x_w[0] = left_w;
  assign e1x_w[1] = rgt_w;
  assign e1x_w[2] = rgt_w;
  assign e1x_w[3] = left_w;
  assign e1y_w[0] = top_w;
  assign e1y_w[1] = top_w;
  assign e1y_w[2] = bot_w;
  assign e1y_w[3] = bot_w;

  always_comb begin
    logic signed [XW-1:0] t1, t2;
    logic [XW-1:0]        a1, a2;
    logic                 in_seg;
    for (int k = 0; k < NE; k++) begin
      t1 = crs_w[k];
      t2 = crs_w[(k + 1) % NE];
      a1 = t1[XW-1] ? XW'(-t1) : XW'(t1);
      a2 = t2[XW-1] ? XW'(-t2) : XW'(t2);
      if (den_w[k] > 0) begin
        in_seg = (num_w[k] >= 0) && (num_w[k] <= den_w[k]);
      end else begin
        in_seg = (num_w[k] <= 0) && (num_w[k] >= den_w[k]);
      end
      edge_nxt[k].hit   = (sgn_f(t1) != sgn_f(t2)) && in_seg;
      edge_nxt[k].horiz = (k % 2) == 0;
      edge_nxt[k].neg   = k >= 2;
      edge_nxt[k].e1x   = e1x_w[k];
      edge_nxt[k].e1y   = e1y_w[k];
      edge_nxt[k].sx    = sx1_r;
      edge_nxt[k].sy    = sy1_r;
      edge_nxt[k].t1    = a1[TW-1:0];
      edge_nxt[k].s     = SW'(a1) + SW'(a2);
    end
  end

  always_ff @(posedge clk) begin
    if (en[msbnh_pkg::ST_F2]) begin
      for (int k = 0; k < NE; k++) begin
        edge_o[k] <= edge_nxt[k];
      end
    end
  end

endmodule

/* hw/rtl/msbnh_edge.sv */
// One edge lane: crossing offset by pipelined division, rounded crossing point,
// squared distance and pipelined square root. Depends on msbnh_pkg.
module msbnh_edge (
  input  logic                       clk,
  input  logic [msbnh_pkg::NST-1:0]  en,
  input  msbnh_pkg::edge_in_t        edge_i,
  input  logic [13:0]                box_side,
  output msbnh_pkg::edge_res_t       res_o
);

  localparam int CW   = msbnh_pkg::CW;
  localparam int TW   = msbnh_pkg::TW;
  localparam int SW   = msbnh_pkg::SW;
  localparam int QW   = msbnh_pkg::QW;
  localparam int NW   = msbnh_pkg::NW;
  localparam int DW   = msbnh_pkg::DW;
  localparam int VW   = msbnh_pkg::VW;
  localparam int SQN  = msbnh_pkg::SQN;
  localparam int DSTW = msbnh_pkg::DSTW;
  localparam int HB   = TW / 2;
  localparam int PPW  = 14 + TW - HB;
  localparam int MW   = 14 + TW;
  localparam int QSW  = VW - 1;

  typedef struct packed {
    logic                 hit;
    logic                 horiz;
    logic                 neg;
    logic signed [CW-1:0] e1x;
    logic signed [CW-1:0] e1y;
    logic signed [15:0]   sx;
    logic signed [15:0]   sy;
  } ctx_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } pt_t;

  ctx_t ctx_w;
  assign ctx_w = '{hit: edge_i.hit, horiz: edge_i.horiz, neg: edge_i.neg,
                   e1x: edge_i.e1x, e1y: edge_i.e1y, sx: edge_i.sx, sy: edge_i.sy};

  // E0: side times offset cross product, in two partial products
  logic [PPW-1:0] plo0_r, phi0_r;
  logic [SW-1:0]  s0_r;
  ctx_t           ctx0_r;

  always_ff @(posedge clk) begin
    if (en[msbnh_pkg::ST_E0]) begin
      plo0_r <= PPW'(box_side) * PPW'(edge_i.t1[HB-1:0]);
      phi0_r <= PPW'(box_side) * PPW'(edge_i.t1[TW-1:HB]);
      s0_r   <= edge_i.s;
      ctx0_r <= ctx_w;
    end
  end

  // E1: dividend 2*side*t1 + s, less one on edges that run backward
  logic [MW-1:0] prod_w;
  logic [NW-1:0] num1_r;
  logic [DW-1:0] den1_r;
  ctx_t          ctx1_r;

  assign prod_w = MW'({phi0_r, {HB{1'b0}}}) + MW'(plo0_r);

  always_ff @(posedge clk) begin
    if (en[msbnh_pkg::ST_E1]) begin
      num1_r <= NW'({prod_w, 1'b0}) + NW'(s0_r) - NW'(ctx0_r.neg);
      den1_r <= DW'({s0_r, 1'b0});
      ctx1_r <= ctx0_r;
    end
  end

  // Restoring division, one quotient bit per stage
  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] dden_r [QW];
  logic [QW-1:0] q_r [QW];
  ctx_t          dctx_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [NW-1:0] r_in, sh;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    ctx_t          c_in;
    logic          ge;
    if (j == 0) begin : g_first
      assign r_in = num1_r;
      assign d_in = den1_r;
      assign q_in = '0;
      assign c_in = ctx1_r;
    end else begin : g_next
      assign r_in = rem_r[j-1];
      assign d_in = dden_r[j-1];
      assign q_in = q_r[j-1];
      assign c_in = dctx_r[j-1];
    end
    assign sh = NW'(d_in) << (QW - 1 - j);
    assign ge = r_in >= sh;
    always_ff @(posedge clk) begin
      if (en[msbnh_pkg::ST_DIV + j]) begin
        rem_r[j]  <= ge ? r_in - sh : r_in;
        dden_r[j] <= d_in;
        q_r[j]    <= q_in | (ge ? (QW'(1) << (QW - 1 - j)) : QW'(0));
        dctx_r[j] <= c_in;
      end
    end
  end

  // PT: crossing point and its offset from the start
  ctx_t                 cq_w;
  logic signed [CW-1:0] step_w, base_w, moved_w, px_w, py_w;
  pt_t                  pt_r;
  logic signed [CW-1:0] ddx_r, ddy_r;

  assign cq_w    = dctx_r[QW-1];
  assign step_w  = cq_w.neg ? -CW'(q_r[QW-1]) : CW'(q_r[QW-1]);
  assign base_w  = cq_w.horiz ? cq_w.e1x : cq_w.e1y;
  assign moved_w = base_w + step_w;
  assign px_w    = cq_w.horiz ? moved_w : cq_w.e1x;
  assign py_w    = cq_w.horiz ? cq_w.e1y : moved_w;

  always_ff @(posedge clk) begin
    if (en[msbnh_pkg::ST_PT]) begin
      pt_r  <= '{hit: cq_w.hit, px: px_w, py: py_w};
      ddx_r <= px_w - CW'(cq_w.sx);
      ddy_r <= py_w - CW'(cq_w.sy);
    end
  end

  // SQ: squares
  logic signed [2*CW-1:0] sqx_w, sqy_w;
  logic [QSW-1:0]         sqx_r, sqy_r;
  pt_t                    pt2_r;

  assign sqx_w = (2*CW)'(ddx_r) * (2*CW)'(ddx_r);
  assign sqy_w = (2*CW)'(ddy_r) * (2*CW)'(ddy_r);

  always_ff @(posedge clk) begin
    if (en[msbnh_pkg::ST_SQ]) begin
      sqx_r <= sqx_w[QSW-1:0];
      sqy_r <= sqy_w[QSW-1:0];
      pt2_r <= pt_r;
    end
  end

  // SUM: squared distance
  logic [VW-1:0] v_r;
  pt_t           pt3_r;

  always_ff @(posedge clk) begin
    if (en[msbnh_pkg::ST_SUM]) begin
      v_r   <= VW'(sqx_r) + VW'(sqy_r);
      pt3_r <= pt2_r;
    end
  end

  // Digit-by-digit square root, one result bit per stage
  logic [VW-1:0] rx_r [SQN];
  logic [VW-1:0] rr_r [SQN];
  pt_t           rp_r [SQN];

  for (genvar j = 0; j < SQN; j++) begin : g_rt
    logic [VW-1:0] x_in, r_in, bit_w, t_w;
    pt_t           p_in;
    logic          ge;
    if (j == 0) begin : g_first
      assign x_in = v_r;
      assign r_in = '0;
      assign p_in = pt3_r;
    end else begin : g_next
      assign x_in = rx_r[j-1];
      assign r_in = rr_r[j-1];
      assign p_in = rp_r[j-1];
    end
    assign bit_w = VW'(1) << (2 * (SQN - 1 - j));
    assign t_w   = r_in + bit_w;
    assign ge    = x_in >= t_w;
    always_ff @(posedge clk) begin
      if (en[msbnh_pkg::ST_RT + j]) begin
        rx_r[j] <= ge ? x_in - t_w : x_in;
        rr_r[j] <= ge ? (r_in >> 1) + bit_w : (r_in >> 1);
        rp_r[j] <= p_in;
      end
    end
  end

  // RND: round to nearest using the leftover remainder
  logic [VW-1:0] rf_w, xf_w;
  pt_t           pf_w;

  assign rf_w = rr_r[SQN-1];
  assign xf_w = rx_r[SQN-1];
  assign pf_w = rp_r[SQN-1];

  always_ff @(posedge clk) begin
    if (en[msbnh_pkg::ST_RND]) begin
      res_o.hit      <= pf_w.hit;
      res_o.px       <= pf_w.px;
      res_o.py       <= pf_w.py;
      res_o.hit_dist <= rf_w[DSTW-1:0] + DSTW'(xf_w > rf_w);
    end
  end

endmodule

/* hw/rtl/motion_segment_box_nearest_hit.sv */
// Top level of the segment versus square box nearest-hit block.
// Depends on msbnh_pkg, msbnh_ctrl, msbnh_front and msbnh_edge.
//
// Usage:
//   Input beats on in_* carry a segment start and its motion vector (signed
//   Q11.4). Each beat gives exactly one output beat on out_*: hit flag, the
//   nearest crossing of the box outline (saturated Q11.4) and its distance
//   (Q12.4, saturated to 65535; 65535 with a zero point when nothing is hit).
//   Ties in distance go to the earlier edge: top, right, bottom, left.
//   The box is set through cfg_we / cfg_index / cfg_wdata: index 0 left x,
//   1 top y, 2 side length; other indexes are ignored. Write only while idle.
// Timing:
//   42-stage pipeline; one beat per cycle sustained while out_tready stays high.
//   Depth is set by the 14-step offset divider and the 18-step square root
//   that each edge lane (top, right, bottom, left) carries.
// Reset (rst_n low, synchronous) empties the pipeline and loads the box
// with corner (64.0, 64.0) and side 64.0.
// Stalls: when out_tready is low the output beat holds; earlier stages keep
// filling bubbles and in_tready drops only once every stage is occupied.
module motion_segment_box_nearest_hit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_x [15:0], start_y [31:16], move_x [47:32], move_y [63:48]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // hit [0], hit_x [16:1], hit_y [32:17], hit_distance [48:33], zero [55:49]
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int NE   = msbnh_pkg::NEDGE;
  localparam int CW   = msbnh_pkg::CW;
  localparam int DSTW = msbnh_pkg::DSTW;

  function automatic logic [15:0] sat16(input logic signed [CW-1:0] v);
    if (v[CW-1:15] == '0 || v[CW-1:15] == '1) begin
      return v[15:0];
    end
    return v[CW-1] ? 16'h8000 : 16'h7fff;
  endfunction

  // Box registers
  logic signed [15:0] box_left_r, box_top_r;
  logic [13:0]        box_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_left_r <= msbnh_pkg::RST_LEFT;
      box_top_r  <= msbnh_pkg::RST_TOP;
      box_side_r <= msbnh_pkg::RST_SIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        msbnh_pkg::CFG_LEFT: box_left_r <= cfg_wdata;
        msbnh_pkg::CFG_TOP:  box_top_r  <= cfg_wdata;
        msbnh_pkg::CFG_SIDE: box_side_r <= cfg_wdata[13:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Stage enables and valid bits
  logic [msbnh_pkg::NST-1:0] en;

  msbnh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .en         (en)
  );

  // Cross products and crossing tests for the top, right, bottom and left edges
  msbnh_pkg::edge_in_t [NE-1:0] edge_w;

  msbnh_front u_front (
    .clk      (clk),
    .en       (en),
    .start_x  (in_tdata[15:0]),
    .start_y  (in_tdata[31:16]),
    .move_x   (in_tdata[47:32]),
    .move_y   (in_tdata[63:48]),
    .box_left (box_left_r),
    .box_top  (box_top_r),
    .box_side (box_side_r),
    .edge_o   (edge_w)
  );

  // One lane per edge: crossing point and distance
  msbnh_pkg::edge_res_t res_w [NE];

  for (genvar k = 0; k < NE; k++) begin : g_edge
    msbnh_edge u_edge (
      .clk      (clk),
      .en       (en),
      .edge_i   (edge_w[k]),
      .box_side (box_side_r),
      .res_o    (res_w[k])
    );
  end

  // Nearest crossing; strict compare keeps the earlier edge on a tie
  logic                 found_w;
  logic signed [CW-1:0] best_x_w, best_y_w;
  logic [DSTW-1:0]      best_d_w;

  always_comb begin
    found_w  = 1'b0;
    best_x_w = '0;
    best_y_w = '0;
    best_d_w = '0;
    for (int k = 0; k < NE; k++) begin
      if (res_w[k].hit && (!found_w || res_w[k].hit_dist < best_d_w)) begin
        found_w  = 1'b1;
        best_x_w = res_w[k].px;
        best_y_w = res_w[k].py;
        best_d_w = res_w[k].hit_dist;
      end
    end
  end

  // Output register: holds the beat until taken
  logic        out_hit_r;
  logic [15:0] out_x_r, out_y_r, out_dist_r;

  always_ff @(posedge clk) begin
    if (en[msbnh_pkg::ST_OUT]) begin
      out_hit_r <= found_w;
      if (found_w) begin
        out_x_r    <= sat16(best_x_w);
        out_y_r    <= sat16(best_y_w);
        out_dist_r <= (best_d_w[DSTW-1:16] != '0) ? 16'hffff : best_d_w[15:0];
      end else begin
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_dist_r <= 16'hffff;
      end
    end
  end

  assign out_tdata = {7'b0, out_dist_r, out_y_r, out_x_r, out_hit_r};

endmodule

/* tb/testbench.sv */
// Testbench for motion_segment_box_nearest_hit: segment versus square box crossing.
// Predicts each result with an integer model of the edge tests; depends on msbnh_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic        hit;
    logic [15:0] hx;
    logic [15:0] hy;
    logic [15:0] hit_dist;
  } hit_res_t;

  localparam int WATCHDOG = 4000;
  localparam int PIPE_LAT = 42;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = msbnh_pkg::CFG_LEFT;
  logic [15:0] cfg_wdata = '0;

  // Box as the block should see it
  longint box_left = 1024, box_top = 1024, box_side = 1024;

  hit_res_t expected_hits[$];
  int  fail_count = 0;
  int  idle_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;

  always #2 clk = ~clk;

  motion_segment_box_nearest_hit dut (.*);

  function automatic longint sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint isqrt_round(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r = r + ((v - (r + 1) * (r + 1)) > 1000000 ?
      longint'($sqrt(real'(v))) - r - 1 > 0 ? longint'($sqrt(real'(v))) - r - 1 : 1 : 1);
    if (v - r * r > r) r++;
    return r;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Nearest crossing of the segment with the box outline, top/right/bottom/left
  function automatic hit_res_t nearest_crossing(logic [63:0] d);
    longint sx, sy, ax, ay, rgt, bot, bx, by, cx, cy, dx, dy, t1, t2, den, num, s;
    longint px, py, dd, best_d, best_x, best_y;
    longint ex1[4], ey1[4], ex2[4], ey2[4];
    bit found;
    hit_res_t r;
    sx = longint'($signed(d[15:0]));  sy = longint'($signed(d[31:16]));
    ax = longint'($signed(d[47:32])); ay = longint'($signed(d[63:48]));
    rgt = box_left + box_side; bot = box_top + box_side;
    ex1 = '{box_left, rgt, rgt, box_left}; ey1 = '{box_top, box_top, bot, bot};
    ex2 = '{rgt, rgt, box_left, box_left}; ey2 = '{box_top, bot, bot, box_top};
    found = 0; best_d = 0; best_x = 0; best_y = 0;
    for (int k = 0; k < 4; k++) begin
      bx = ex2[k] - ex1[k]; by = ey2[k] - ey1[k];
      cx = ex1[k] - sx; cy = ey1[k] - sy;
      dx = ex2[k] - sx; dy = ey2[k] - sy;
      t1 = ax * cy - ay * cx;
      t2 = ax * dy - ay * dx;
      if (sgn(t1) == sgn(t2)) continue;
      den = ax * by - ay * bx;
      num = cx * by - cy * bx;
      if (den > 0) begin
        if (num < 0 || num > den) continue;
      end else begin
        if (num > 0 || num < den) continue;
      end
      if (t1 < 0) t1 = -t1;
      if (t2 < 0) t2 = -t2;
      s = t1 + t2;
      px = ex1[k] + fdiv(2 * bx * t1 + s, 2 * s);
      py = ey1[k] + fdiv(2 * by * t1 + s, 2 * s);
      dd = isqrt_round((px - sx) * (px - sx) + (py - sy) * (py - sy));
      if (!found || dd < best_d) begin
        found = 1; best_d = dd; best_x = px; best_y = py;
      end
    end
    r.hit      = found;
    r.hx       = found ? clamp16(best_x) : 16'd0;
    r.hy       = found ? clamp16(best_y) : 16'd0;
    r.hit_dist = (!found || best_d > 65535) ? 16'hFFFF : best_d[15:0];
    return r;
  endfunction

  // Write one box register; block must be idle
  task automatic write_box(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      msbnh_pkg::CFG_LEFT: box_left = longint'($signed(val));
      msbnh_pkg::CFG_TOP:  box_top  = longint'($signed(val));
      msbnh_pkg::CFG_SIDE: box_side = longint'(val[13:0]);
      default: ;
    endcase
  endtask

  // Send one segment beat, idling first at the current rate; tvalid stays
  // high after the beat so the next call can follow without a gap
  task automatic send_segment(logic [15:0] sx, logic [15:0] sy,
                              logic [15:0] mx, logic [15:0] my);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {my, mx, sy, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_hits.push_back(nearest_crossing({my, mx, sy, sx}));
    @(negedge clk);
  endtask

  // Drop tvalid, wait for the pipe to drain, then let the latency pass
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] coord_near(longint c);
    longint v;
    v = c + $signed($urandom_range(4096)) - 2048;
    return clamp16(v);
  endfunction

  // Random segment: mostly aimed near the box, some wild
  task automatic send_random_segment;
    logic [15:0] sx, sy, mx, my;
    if ($urandom_range(3) == 0) begin
      sx = 16'($urandom); sy = 16'($urandom); mx = 16'($urandom); my = 16'($urandom);
    end else begin
      sx = coord_near(box_left + box_side / 2);
      sy = coord_near(box_top + box_side / 2);
      mx = coord_near(box_left + $urandom_range(32'(box_side))) - sx;
      my = coord_near(box_top + $urandom_range(32'(box_side))) - sy;
      if ($urandom_range(7) == 0) begin
        mx = mx <<< $urandom_range(4);
        my = my <<< $urandom_range(4);
      end
    end
    send_segment(sx, sy, mx, my);
  endtask

  task automatic test_directed;
    send_segment(16'd1536, 16'd1536, 16'd0, 16'd0);          // zero motion
    send_segment(16'd1536, 16'd1536, 16'd1024, 16'd0);       // exits right edge
    send_segment(16'd1536, 16'd0, 16'd0, 16'd3072);          // crosses top and bottom
    send_segment(16'd0, 16'd0, 16'd3072, 16'd3072);          // diagonal through corners
    send_segment(16'd0, 16'd1024, 16'd4096, 16'd0);          // along the top edge
    send_segment(16'd1536, 16'd1536, 16'd100, 16'd0);        // inside, no reach
    send_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);    // field extremes
    send_segment(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_segment(16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF);
    send_segment(16'd512, 16'd2048, 16'd2048, 16'd0);        // equal hits from left
    drain();
  endtask

  task automatic test_box_settings;
    write_box(msbnh_pkg::CFG_SIDE, 16'd0);                   // degenerate box
    send_segment(16'd0, 16'd0, 16'd3072, 16'd3072);
    send_segment(16'd512, 16'd1024, 16'd2048, 16'd0);
    drain();
    write_box(msbnh_pkg::CFG_LEFT, 16'h8000);
    write_box(msbnh_pkg::CFG_TOP, 16'h7FFF);
    write_box(msbnh_pkg::CFG_SIDE, 16'h3FFF);                // corners far off range
    send_segment(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_segment(16'h0000, 16'h7FF0, 16'h8000, 16'h0000);
    for (int i = 0; i < 20; i++) send_random_segment();
    drain();
    write_box(2'd3, 16'h1234);                               // unused index
    write_box(msbnh_pkg::CFG_LEFT, 16'h7FFF);
    write_box(msbnh_pkg::CFG_TOP, 16'h8000);
    write_box(msbnh_pkg::CFG_SIDE, 16'd16);
    for (int i = 0; i < 20; i++) send_random_segment();
    drain();
  endtask

  task automatic test_random_phase(int snd, int rcv, int n);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    write_box(msbnh_pkg::CFG_LEFT, 16'($urandom_range(2048)) - 16'd1024);
    write_box(msbnh_pkg::CFG_TOP, 16'($urandom_range(2048)) - 16'd1024);
    write_box(msbnh_pkg::CFG_SIDE, 16'($urandom_range(16, 3000)));
    for (int i = 0; i < n; i++) send_random_segment();
    drain();
  endtask

  // Drive out_tready at random on the falling edge
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    hit_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[0], out_tdata[16:1], out_tdata[32:17], out_tdata[48:33]};
      if (expected_hits.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_hits.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d actual %0d", want.hit, got.hit); fail_count++;
        end
        if (got.hx !== want.hx) begin
          $error("hit_x: expected %h actual %h", want.hx, got.hx); fail_count++;
        end
        if (got.hy !== want.hy) begin
          $error("hit_y: expected %h actual %h", want.hy, got.hy); fail_count++;
        end
        if (got.hit_dist !== want.hit_dist) begin
          $error("hit_distance: expected %0d actual %0d", want.hit_dist, got.hit_dist);
          fail_count++;
        end
        if (out_tdata[55:49] !== 7'd0) begin
          $error("pad: expected 0 actual %h", out_tdata[55:49]); fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_box_settings();
    test_random_phase(30, 86, 130);
    test_random_phase(86, 30, 130);
    test_random_phase(0, 0, 130);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
